[hw/rtl/positional_list_store_unit_defines.svh]
// ----------------------------------------------------------------------------
// Positional list store - assertion macros
// Shared assertion shorthands; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_STORE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset
`define PLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define PLS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define PLS_ASSERT(lbl, prop, msg)
`define PLS_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

[hw/rtl/pls_pkg.sv]
// ----------------------------------------------------------------------------
// Positional list store - package
// Request, response, command and status types used across the modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pls_pkg;

  // Field widths of the request and response beats
  localparam int unsigned POS_W  = 7;
  localparam int unsigned POS2_W = 6;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned CNT_W  = 7;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_SWAP   = 2'd2,
    MODE_GET    = 2'd3
  } pls_mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } pls_status_e;

  // Memory read address source
  typedef enum logic [1:0] {
    RD_POS    = 2'd0,
    RD_POS2   = 2'd1,
    RD_CUR_M1 = 2'd2,
    RD_CUR_P1 = 2'd3
  } pls_rd_sel_e;

  // Memory write address source
  typedef enum logic [1:0] {
    WA_POS  = 2'd0,
    WA_POS2 = 2'd1,
    WA_CUR  = 2'd2
  } pls_wa_sel_e;

  // Memory write data source
  typedef enum logic [1:0] {
    WD_RDATA = 2'd0,
    WD_VALUE = 2'd1,
    WD_TMP   = 2'd2
  } pls_wd_sel_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [POS_W-1:0]  position;
    logic [POS2_W-1:0] second_position;
    logic [VAL_W-1:0]  entry_value;
  } pls_req_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic [1:0]       status;
    logic [CNT_W-1:0] entry_count;
  } pls_rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic        load;
    logic        check;
    logic        rd_en;
    pls_rd_sel_e rd_sel;
    logic        wr_en;
    pls_wa_sel_e wa_sel;
    pls_wd_sel_e wd_sel;
    logic        cur_ld_cnt;
    logic        cur_ld_pos;
    logic        cur_inc;
    logic        cur_dec;
    logic        cap_rval;
    logic        cap_tmp;
    logic        cnt_inc;
    logic        cnt_dec;
  } pls_cmd_t;

  // Datapath to controller
  typedef struct packed {
    pls_mode_e mode;
    logic      err;
    logic      up_start;
    logic      up_last;
    logic      dn_start;
    logic      dn_more;
  } pls_stat_t;

endpackage

`default_nettype wire

[hw/rtl/positional_list_store_unit.sv]
// Positional list store: insert, remove, swap and get on an ordered list in a memory.
// A range or full error ends a request right after the check; insert and remove also move
// every entry between the position and the end of the list, one move at a time.
// Each entry move is a read, then a write, on the single-port-pair entry memory.
// A new beat is taken in the cycle the result is shown; results cannot be stalled.
// Reset clears count and controller only; memory contents stay undefined until written.
// ----------------------------------------------------------------------------
// Positional list store unit - top level
// Joins the sequencing controller with the entry datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module positional_list_store_unit #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned ENTRY_WIDTH = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire pls_pkg::pls_req_t req_i,
  output logic                   busy,
  output logic                   done_o,
  output pls_pkg::pls_rsp_t      rsp_o
);
  import pls_pkg::*;

  pls_cmd_t  cmd;
  pls_stat_t stat;

  pls_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  pls_datapath #(
    .CAPACITY    (CAPACITY),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .rsp_o  (rsp_o)
  );

endmodule

`default_nettype wire

[hw/rtl/pls_datapath.sv]
// ----------------------------------------------------------------------------
// Positional list store - datapath
// Entry memory, count, cursor, request hold and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "positional_list_store_unit_defines.svh"

module pls_datapath #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned ENTRY_WIDTH = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pls_pkg::pls_req_t req_i,
  input  wire pls_pkg::pls_cmd_t cmd_i,
  output pls_pkg::pls_stat_t     stat_o,
  output pls_pkg::pls_rsp_t      rsp_o
);
  import pls_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = ((CW > POS_W) ? CW : POS_W) + 1;

  pls_req_t               req_q;
  logic [CW-1:0]          count_q, count_d;
  logic [AW-1:0]          cur_q, cur_d;
  logic [ENTRY_WIDTH-1:0] rdata_q;
  logic [ENTRY_WIDTH-1:0] tmp_q;
  logic [VAL_W-1:0]       rval_q;
  logic [1:0]             st_q;
  logic [ENTRY_WIDTH-1:0] mem_q [CAPACITY];

  logic [XW-1:0]          pos_x, pos2_x, cnt_x, cur_x, cap_x;
  logic                   err_range, err_full;
  pls_status_e            st_code;
  logic [AW-1:0]          pos_a, pos2_a, raddr, waddr;
  logic [ENTRY_WIDTH-1:0] wdata;

  // Widen operands to a common compare width
  assign pos_x  = XW'(req_q.position);
  assign pos2_x = XW'(req_q.second_position);
  assign cnt_x  = XW'(count_q);
  assign cur_x  = XW'(cur_q);
  assign cap_x  = XW'(CAPACITY);
  assign pos_a  = AW'(req_q.position);
  assign pos2_a = AW'(req_q.second_position);

  // Range and capacity checks on the held request
  always_comb begin
    err_range = 1'b0;
    err_full  = 1'b0;
    unique case (req_q.mode)
      MODE_INSERT: begin
        err_range = (pos_x > cnt_x);
        err_full  = !err_range && (cnt_x == cap_x);
      end
      MODE_REMOVE: err_range = (pos_x >= cnt_x);
      MODE_SWAP:   err_range = (pos_x >= cnt_x) || (pos2_x >= cnt_x);
      MODE_GET:    err_range = (pos_x >= cnt_x);
      default: begin
        err_range = 1'b0;
        err_full  = 1'b0;
      end
    endcase
  end

  assign st_code = err_range ? ST_RANGE : (err_full ? ST_FULL : ST_OK);

  // Status towards the controller
  assign stat_o.mode     = pls_mode_e'(req_q.mode);
  assign stat_o.err      = err_range || err_full;
  assign stat_o.up_start = (cnt_x != pos_x);
  assign stat_o.up_last  = (cur_x == pos_x + XW'(1));
  assign stat_o.dn_start = (cur_x + XW'(1) < cnt_x);
  assign stat_o.dn_more  = (cur_x + XW'(2) < cnt_x);

  // Address and data selection
  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_POS:    raddr = pos_a;
      RD_POS2:   raddr = pos2_a;
      RD_CUR_M1: raddr = cur_q - AW'(1);
      RD_CUR_P1: raddr = cur_q + AW'(1);
      default:   raddr = pos_a;
    endcase
  end

  always_comb begin
    unique case (cmd_i.wa_sel)
      WA_POS:  waddr = pos_a;
      WA_POS2: waddr = pos2_a;
      WA_CUR:  waddr = cur_q;
      default: waddr = cur_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.wd_sel)
      WD_RDATA: wdata = rdata_q;
      WD_VALUE: wdata = ENTRY_WIDTH'(req_q.entry_value);
      WD_TMP:   wdata = tmp_q;
      default:  wdata = rdata_q;
    endcase
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // Cursor walks the shift range
  always_comb begin
    cur_d = cur_q;
    if (cmd_i.cur_ld_cnt) begin
      cur_d = AW'(count_q);
    end else if (cmd_i.cur_ld_pos) begin
      cur_d = pos_a;
    end else if (cmd_i.cur_inc) begin
      cur_d = cur_q + AW'(1);
    end else if (cmd_i.cur_dec) begin
      cur_d = cur_q - AW'(1);
    end
  end

  // Count advances on insert, drops on remove
  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Request hold, swap temporary and result registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.cap_tmp) begin
      tmp_q <= rdata_q;
    end
    if (cmd_i.check) begin
      st_q <= st_code;
    end
    if (cmd_i.load) begin
      rval_q <= '0;
    end else if (cmd_i.cap_rval) begin
      rval_q <= VAL_W'(rdata_q);
    end
  end

  assign rsp_o.read_value  = rval_q;
  assign rsp_o.status      = st_q;
  assign rsp_o.entry_count = CNT_W'(count_q);

  `PLS_ASSERT(a_count_bound, count_q <= CW'(CAPACITY), "count exceeds capacity")
  `PLS_ASSERT(a_inc_not_full, cmd_i.cnt_inc |-> cnt_x < cap_x, "insert into full store")
  `PLS_ASSERT_NEVER(a_dec_empty, cmd_i.cnt_dec && (count_q == '0), "remove from empty store")

endmodule

`default_nettype wire

[hw/rtl/pls_ctrl.sv]
// ----------------------------------------------------------------------------
// Positional list store - controller
// Sequences checks, memory reads, entry moves and the result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "positional_list_store_unit_defines.svh"

module pls_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  output logic                    done_o,
  input  wire pls_pkg::pls_stat_t stat_i,
  output pls_pkg::pls_cmd_t       cmd_o
);
  import pls_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_CHECK  = 12'b0000_0000_0010,
    S_UP_RD  = 12'b0000_0000_0100,
    S_UP_WR  = 12'b0000_0000_1000,
    S_INS    = 12'b0000_0001_0000,
    S_CAPT   = 12'b0000_0010_0000,
    S_DN_RD  = 12'b0000_0100_0000,
    S_DN_WR  = 12'b0000_1000_0000,
    S_SW_RD2 = 12'b0001_0000_0000,
    S_SW_WR1 = 12'b0010_0000_0000,
    S_SW_WR2 = 12'b0100_0000_0000,
    S_DONE   = 12'b1000_0000_0000
  } pls_state_e;

  pls_state_e state_q, state_d;
  logic       accept;

  // Take a new beat while idle or while the last result is on show
  assign busy_o = !((state_q == S_IDLE) || (state_q == S_DONE));
  assign done_o = (state_q == S_DONE);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q) inside
      S_IDLE, S_DONE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        if (stat_i.err) begin
          state_d = S_DONE;
        end else begin
          unique case (stat_i.mode) inside
            MODE_INSERT: begin
              if (stat_i.up_start) begin
                cmd_o.cur_ld_cnt = 1'b1;
                state_d          = S_UP_RD;
              end else begin
                state_d = S_INS;
              end
            end
            MODE_REMOVE, MODE_GET: begin
              cmd_o.rd_en      = 1'b1;
              cmd_o.rd_sel     = RD_POS;
              cmd_o.cur_ld_pos = 1'b1;
              state_d          = S_CAPT;
            end
            MODE_SWAP: begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RD_POS;
              state_d      = S_SW_RD2;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      // Move entries up, from the top down to the insert position
      S_UP_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_CUR_M1;
        state_d      = S_UP_WR;
      end
      S_UP_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wa_sel  = WA_CUR;
        cmd_o.wd_sel  = WD_RDATA;
        cmd_o.cur_dec = 1'b1;
        state_d       = stat_i.up_last ? S_INS : S_UP_RD;
      end
      S_INS: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wa_sel  = WA_POS;
        cmd_o.wd_sel  = WD_VALUE;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_DONE;
      end
      // Capture the entry read for remove or get
      S_CAPT: begin
        cmd_o.cap_rval = 1'b1;
        if (stat_i.mode == MODE_REMOVE) begin
          if (stat_i.dn_start) begin
            state_d = S_DN_RD;
          end else begin
            cmd_o.cnt_dec = 1'b1;
            state_d       = S_DONE;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      // Close the gap, from the removed position upwards
      S_DN_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_CUR_P1;
        state_d      = S_DN_WR;
      end
      S_DN_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wa_sel  = WA_CUR;
        cmd_o.wd_sel  = WD_RDATA;
        cmd_o.cur_inc = 1'b1;
        if (stat_i.dn_more) begin
          state_d = S_DN_RD;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_DONE;
        end
      end
      // Swap: hold the first entry, read the second, write both back
      S_SW_RD2: begin
        cmd_o.cap_tmp = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = RD_POS2;
        state_d       = S_SW_WR1;
      end
      S_SW_WR1: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wa_sel = WA_POS;
        cmd_o.wd_sel = WD_RDATA;
        state_d      = S_SW_WR2;
      end
      S_SW_WR2: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wa_sel = WA_POS2;
        cmd_o.wd_sel = WD_TMP;
        state_d      = S_DONE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `PLS_ASSERT(a_done_single, done_o |=> !done_o, "result strobe longer than one cycle")
  `PLS_ASSERT(a_cnt_then_done, (cmd_o.cnt_inc || cmd_o.cnt_dec) |=> done_o, "count change without result")
  `PLS_ASSERT(a_done_after_busy, done_o |-> $past(busy_o), "result without work")

endmodule

`default_nettype wire
